// ===== design/los_pkg.sv =====
package los_pkg;
  localparam int Capacity = 16;
  localparam int MaxOut = 16;
  localparam int IdxW = $clog2(Capacity + 1);
  localparam int AddrW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam logic [IdxW-1:0] Nil = IdxW'(Capacity);
  localparam int LinkW = 2 * IdxW;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;
endpackage

// ===== design/los_ram.sv =====
module los_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== design/linked_ordered_set.sv =====
// One operation per input transaction (append at the tail, insert before an anchor
// key, remove, or none), then the whole list is emitted from head to tail, one result
// per cycle while out_ready is high, or a single result flagged empty. Keys and the
// {prev, next} links live in two single-port-read memories with registered reads;
// the valid bits are flip-flops, so unwritten entries are never used and no clearing
// pass is needed. Sequence between accepted input transactions: the idle state, a
// key scan over every slot (key and anchor are matched in the same pass), a decision
// state, six link read-modify-write states only when the list changes, a state to
// start the walk and the emit state, which outputs the results in turn and holds
// while out_ready is low. in_ready is high only while idle.
module linked_ordered_set (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_anchor_key,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_value,
  output logic [3:0]  out_position,
  output logic [1:0]  out_status,
  output logic        out_list_empty,
  output logic        out_last
);
  import los_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_SCAN   = 11'b00000000010,
    S_DEC    = 11'b00000000100,
    S_RDA    = 11'b00000001000,
    S_CAP    = 11'b00000010000,
    S_RDL    = 11'b00000100000,
    S_WRL    = 11'b00001000000,
    S_WRR    = 11'b00010000000,
    S_COMMIT = 11'b00100000000,
    S_WALK   = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] op_r;
  logic [31:0] key_r, anc_r;
  logic [Capacity-1:0] valid_r;
  logic [IdxW-1:0] head_r, tail_r;
  logic [CntW-1:0] count_r;
  logic [IdxW-1:0] kslot_r, aslot_r;
  logic [CntW-1:0] scan_r;
  status_t status_r;
  logic [IdxW-1:0] slot_r, left_r, right_r, cur_r;
  logic [CntW-1:0] n_r;

  logic k_we;
  logic [AddrW-1:0] k_waddr, k_raddr;
  logic [31:0] k_wdata, k_rdata;
  logic l_we;
  logic [AddrW-1:0] l_waddr, l_raddr;
  logic [LinkW-1:0] l_wdata, l_rdata;
  logic [IdxW-1:0] rd_prev, rd_next;
  logic [IdxW-1:0] free_idx;
  logic [AddrW-1:0] scan_idx;
  logic inserting;
  status_t dec_status;
  logic dec_apply;
  logic emit_last;

  // key memory
  los_ram #(.Width(32), .Depth(Capacity)) u_keys (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(k_wdata),
    .raddr(k_raddr), .rdata(k_rdata));

  // link memory {prev, next}
  los_ram #(.Width(LinkW), .Depth(Capacity)) u_links (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_raddr), .rdata(l_rdata));

  assign rd_prev = l_rdata[LinkW-1:IdxW];
  assign rd_next = l_rdata[IdxW-1:0];

  always_comb begin
    free_idx = Nil;
    for (int i = Capacity - 1; i >= 0; i--)
      if (!valid_r[i]) free_idx = IdxW'(i);
  end

  assign inserting = (op_r == OP_APPEND) || (op_r == OP_INSERT);
  // key read data in the scan belongs to the address issued in the previous cycle
  assign scan_idx = AddrW'(scan_r - CntW'(1));

  always_comb begin
    dec_status = ST_DONE;
    dec_apply = 1'b0;
    if (inserting) begin
      if (kslot_r != Nil) dec_status = ST_DUP;
      else if (op_r == OP_INSERT && aslot_r == Nil) dec_status = ST_ABSENT;
      else if (free_idx == Nil) dec_status = ST_FULL;
      else dec_apply = 1'b1;
    end else if (op_r == OP_REMOVE) begin
      if (kslot_r == Nil) dec_status = ST_ABSENT;
      else dec_apply = 1'b1;
    end
  end

  assign emit_last = (count_r == '0) || (n_r + CntW'(1) == count_r) ||
                     (n_r == CntW'(MaxOut - 1));

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    k_we = 1'b0;
    k_waddr = slot_r[AddrW-1:0];
    k_wdata = key_r;
    k_raddr = cur_r[AddrW-1:0];
    l_we = 1'b0;
    l_waddr = slot_r[AddrW-1:0];
    l_wdata = {left_r, right_r};
    l_raddr = cur_r[AddrW-1:0];
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_SCAN;
      S_SCAN: begin
        k_raddr = scan_r[AddrW-1:0];
        if (scan_r == CntW'(Capacity)) state_nxt = S_DEC;
      end
      S_DEC: state_nxt = dec_apply ? S_RDA : S_WALK;
      S_RDA: begin
        l_raddr = inserting ? right_r[AddrW-1:0] : slot_r[AddrW-1:0];
        state_nxt = S_CAP;
      end
      S_CAP: state_nxt = S_RDL;
      S_RDL: begin
        l_raddr = left_r[AddrW-1:0];
        state_nxt = S_WRL;
      end
      S_WRL: begin
        // patch the left neighbour's next link, fetch the right neighbour
        l_we = (left_r != Nil);
        l_waddr = left_r[AddrW-1:0];
        l_wdata = {rd_prev, inserting ? slot_r : right_r};
        l_raddr = right_r[AddrW-1:0];
        state_nxt = S_WRR;
      end
      S_WRR: begin
        l_we = (right_r != Nil);
        l_waddr = right_r[AddrW-1:0];
        l_wdata = {inserting ? slot_r : left_r, rd_next};
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        k_we = inserting;
        l_we = inserting;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        k_raddr = head_r[AddrW-1:0];
        l_raddr = head_r[AddrW-1:0];
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        // re-read the current entry while stalled so the result holds
        if (out_ready && !emit_last) begin
          k_raddr = rd_next[AddrW-1:0];
          l_raddr = rd_next[AddrW-1:0];
        end
        if (out_ready && emit_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      head_r <= Nil;
      tail_r <= Nil;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_op;
          key_r <= in_key;
          anc_r <= in_anchor_key;
          kslot_r <= Nil;
          aslot_r <= Nil;
          scan_r <= '0;
        end
        S_SCAN: begin
          if (scan_r != '0 && valid_r[scan_idx]) begin
            if (k_rdata == key_r) kslot_r <= IdxW'(scan_idx);
            if (k_rdata == anc_r) aslot_r <= IdxW'(scan_idx);
          end
          scan_r <= scan_r + CntW'(1);
        end
        S_DEC: begin
          status_r <= dec_status;
          slot_r <= inserting ? free_idx : kslot_r;
          right_r <= (op_r == OP_INSERT) ? aslot_r : Nil;
        end
        S_CAP: begin
          if (inserting) begin
            left_r <= (right_r == Nil) ? tail_r : rd_prev;
          end else begin
            left_r <= rd_prev;
            right_r <= rd_next;
          end
        end
        S_COMMIT: begin
          if (inserting) begin
            valid_r[slot_r[AddrW-1:0]] <= 1'b1;
            count_r <= count_r + CntW'(1);
            if (right_r == Nil) tail_r <= slot_r;
            if (left_r == Nil) head_r <= slot_r;
          end else begin
            valid_r[slot_r[AddrW-1:0]] <= 1'b0;
            count_r <= count_r - CntW'(1);
            if (left_r == Nil) head_r <= right_r;
            if (right_r == Nil) tail_r <= left_r;
          end
        end
        S_WALK: begin
          n_r <= '0;
          cur_r <= head_r;
        end
        S_EMIT: if (out_ready && !emit_last) begin
          n_r <= n_r + CntW'(1);
          cur_r <= rd_next;
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state_r == S_EMIT);
  assign out_list_empty = (count_r == '0);
  assign out_value = out_list_empty ? '0 : k_rdata;
  assign out_position = n_r[3:0];
  assign out_status = status_r;
  assign out_last = emit_last;

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) &&
      $stable(out_position) && $stable(out_last));
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CntW'(Capacity));
  a_head_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (head_r == Nil) == (count_r == '0));
  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid));
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_list_empty |-> out_last);
`endif
endmodule

// ===== sim/linked_ordered_set_checker.sv =====
module linked_ordered_set_checker
  import los_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [31:0] in_key,
  input  logic signed [31:0] in_anchor_key,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_value,
  input  logic [3:0]         out_position,
  input  logic [1:0]         out_status,
  input  logic               out_list_empty,
  input  logic               out_last,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [31:0] value;
    logic [3:0]         position;
    status_t            status;
    logic               list_empty;
    logic               last;
  } listing_t;

  // ordered list of keys, head first
  logic signed [31:0] set_keys[$];
  listing_t listing_q[$];

  assign pending = listing_q.size();

  function automatic int locate(logic signed [31:0] k);
    foreach (set_keys[i]) if (set_keys[i] == k) return i;
    return -1;
  endfunction

  task automatic apply_op(logic [1:0] op, logic signed [31:0] k, logic signed [31:0] a);
    status_t st;
    int pos;
    listing_t r;
    int n;
    st = ST_DONE;
    pos = -1;
    if (op == OP_APPEND || op == OP_INSERT) begin
      if (op == OP_INSERT) pos = locate(a);
      if (locate(k) >= 0) st = ST_DUP;
      else if (op == OP_INSERT && pos < 0) st = ST_ABSENT;
      else if (set_keys.size() >= Capacity) st = ST_FULL;
      else if (op == OP_APPEND) set_keys.push_back(k);
      else set_keys.insert(pos, k);
    end else if (op == OP_REMOVE) begin
      pos = locate(k);
      if (pos < 0) st = ST_ABSENT;
      else set_keys.delete(pos);
    end
    n = (set_keys.size() > MaxOut) ? MaxOut : set_keys.size();
    if (n == 0) begin
      r = '{value: '0, position: '0, status: st, list_empty: 1'b1, last: 1'b1};
      listing_q.push_back(r);
    end
    for (int i = 0; i < n; i++) begin
      r = '{value: set_keys[i], position: 4'(i), status: st, list_empty: 1'b0,
            last: (i == n - 1)};
      listing_q.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    listing_t e;
    if (!rst_n) begin
      fail_count <= 0;
    end else begin
      if (in_valid && in_ready) apply_op(in_op, in_key, in_anchor_key);
      if (out_valid && out_ready) begin
        if (listing_q.size() == 0) begin
          $error("unexpected result transaction value=%0d", out_value);
          fail_count <= fail_count + 1;
        end else begin
          e = listing_q.pop_front();
          if (out_list_empty != e.list_empty ||
              (!e.list_empty && out_value !== e.value) ||
              out_position !== e.position || out_status !== e.status ||
              out_last !== e.last)
            fail_count <= fail_count + 1;
          if (out_list_empty !== e.list_empty)
            $error("list_empty expected %0d got %0d", e.list_empty, out_list_empty);
          if (!e.list_empty && out_value !== e.value)
            $error("value expected %0d got %0d", e.value, out_value);
          if (out_position !== e.position)
            $error("position expected %0d got %0d", e.position, out_position);
          if (out_status !== e.status)
            $error("status expected %0d got %0d", e.status, out_status);
          if (out_last !== e.last)
            $error("last expected %0d got %0d", e.last, out_last);
        end
      end
    end
  end

endmodule

// ===== sim/linked_ordered_set_test.sv =====
module linked_ordered_set_test;
  import los_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_op = '0;
  logic signed [31:0] in_key = '0;
  logic signed [31:0] in_anchor_key = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_value;
  logic [3:0] out_position;
  logic [1:0] out_status;
  logic out_list_empty;
  logic out_last;
  int fail_count;
  int pending;
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  logic signed [31:0] recent[$];

  always #10 clk = ~clk;

  linked_ordered_set dut (.*);

  linked_ordered_set_checker chk (.*);

  // receiver: random stalls, one long hold-off
  initial begin
    int cnt;
    @(posedge clk iff rst_n);
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 1'b0;
        for (cnt = 0; cnt < 400; cnt++) @(posedge clk);
        hold_off = 1'b0;
      end
      out_ready <= calm || ($urandom_range(99) >= 31);
    end
  end

  function automatic logic signed [31:0] pick_key();
    if (recent.size() > 0 && $urandom_range(99) < 55)
      return recent[$urandom_range(recent.size() - 1)];
    if ($urandom_range(3) == 0) return $urandom;
    return $signed(32'($urandom_range(40))) - 20;
  endfunction

  task automatic send(logic [1:0] op, logic signed [31:0] k, logic signed [31:0] a);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_key <= k;
    in_anchor_key <= a;
    recent.push_back(k);
    if (recent.size() > 24) void'(recent.pop_front());
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    logic [1:0] op;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed: empty cases, extremes, each status, fill to capacity
    send(OP_REMOVE, 32'sd5, 0);
    send(OP_NONE, 0, 0);
    send(OP_INSERT, 32'sd1, 32'sd2);
    send(OP_APPEND, 32'h7fffffff, 0);
    send(OP_APPEND, 32'h80000000, 0);
    send(OP_APPEND, 32'h7fffffff, 0);
    send(OP_INSERT, 32'sd0, 32'h7fffffff);
    send(OP_INSERT, 32'sd0, 32'sd0);
    send(OP_INSERT, 32'sd3, 32'sd3);
    send(OP_INSERT, -32'sd1, 32'h80000000);
    for (int i = 0; i < 13; i++) send(OP_APPEND, 32'sd100 + i, 0);
    send(OP_APPEND, 32'sd999, 0);
    send(OP_INSERT, 32'sd998, 32'sd100);
    send(OP_REMOVE, 32'h80000000, 0);
    send(OP_REMOVE, 32'h55555555, 0);
    // random, with a quiet stretch and a long receiver hold-off
    for (int n = 0; n < 195; n++) begin
      calm = (n >= 60 && n < 100);
      if (n == 120) hold_off = 1'b1;
      op = $urandom_range(99) < 40 ? OP_APPEND : ($urandom_range(99) < 55 ? OP_INSERT :
           ($urandom_range(99) < 92 ? OP_REMOVE : OP_NONE));
      send(op, pick_key(), pick_key());
    end
    in_valid <= 1'b0;
    calm = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== linked_ordered_set.f =====
design/los_pkg.sv
design/los_ram.sv
design/linked_ordered_set.sv
sim/linked_ordered_set_checker.sv
sim/linked_ordered_set_test.sv
